### hw/rtl/bce_pkg.sv
// shared types, instruction codes and memory preload for the instruction executor
package bce_pkg;

  localparam int MemWords = 4096;
  localparam int AddrW    = 12;
  localparam int WordW    = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;

  localparam addr_t AddrMax = addr_t'(MemWords - 1);

  // memory-reference opcodes, bits 14-12
  localparam logic [2:0] OpAnd = 3'd0;
  localparam logic [2:0] OpAdd = 3'd1;
  localparam logic [2:0] OpLda = 3'd2;
  localparam logic [2:0] OpSta = 3'd3;
  localparam logic [2:0] OpBun = 3'd4;
  localparam logic [2:0] OpBsa = 3'd5;
  localparam logic [2:0] OpIsz = 3'd6;
  localparam logic [2:0] OpExt = 3'd7;

  // register-reference words
  localparam word_t RegCla = 16'h7800;
  localparam word_t RegCle = 16'h7400;
  localparam word_t RegCma = 16'h7200;
  localparam word_t RegCme = 16'h7100;
  localparam word_t RegCir = 16'h7080;
  localparam word_t RegCil = 16'h7040;
  localparam word_t RegInc = 16'h7020;
  localparam word_t RegSpa = 16'h7010;
  localparam word_t RegSna = 16'h7008;
  localparam word_t RegSza = 16'h7004;
  localparam word_t RegSze = 16'h7002;
  localparam word_t RegHlt = 16'h7001;

  // i/o words
  localparam word_t IoInp = 16'hF800;
  localparam word_t IoOut = 16'hF400;
  localparam word_t IoSki = 16'hF200;
  localparam word_t IoSko = 16'hF100;
  localparam word_t IoIon = 16'hF080;
  localparam word_t IoIof = 16'hF040;

  typedef struct packed {
    word_t instruction;
    word_t input_data;
  } item_t;

  typedef struct packed {
    word_t acc;
    logic  extend_bit;
    addr_t prog_counter;
    logic  out_valid;
    logic  in_flag;
    logic  out_flag;
    logic  irq_enabled;
    logic  halted;
    logic  unknown_instr;
  } res_t;

  typedef struct packed {
    logic  en;
    logic  we;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic take;
    logic clear_done;
  } exec_stat_t;

  // power-up contents of the low words
  function automatic word_t preload_word(addr_t a);
    word_t v;
    case (a)
      addr_t'(0): v = 16'd1;
      addr_t'(1): v = 16'd1100;
      addr_t'(2): v = 16'd1200;
      addr_t'(3): v = 16'd1300;
      addr_t'(4): v = 16'd1400;
      addr_t'(5): v = 16'd1500;
      addr_t'(6): v = 16'd1600;
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/bce_if.sv
// valid/ready channel interfaces for instruction items and results
interface bce_in_if;
  logic         valid;
  logic         ready;
  logic [15:0]  instruction;
  logic [15:0]  input_data;

  modport source (output valid, output instruction, output input_data, input ready);
  modport sink   (input valid, input instruction, input input_data, output ready);
endinterface

interface bce_out_if;
  logic         valid;
  logic         ready;
  logic [15:0]  acc;
  logic         extend_bit;
  logic [11:0]  prog_counter;
  logic         out_valid;
  logic         in_flag;
  logic         out_flag;
  logic         irq_enabled;
  logic         halted;
  logic         unknown_instr;

  modport source (output valid, output acc, output extend_bit, output prog_counter,
                  output out_valid, output in_flag, output out_flag, output irq_enabled,
                  output halted, output unknown_instr, input ready);
  modport sink   (input valid, input acc, input extend_bit, input prog_counter,
                  input out_valid, input in_flag, input out_flag, input irq_enabled,
                  input halted, input unknown_instr, output ready);
endinterface

### hw/rtl/bce_mem.sv
// single-port synchronous main memory, registered read
module bce_mem (
  input  logic              clk,
  input  bce_pkg::mem_req_t req,
  output bce_pkg::word_t    rd_data
);
  import bce_pkg::*;

  word_t mem [MemWords];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rd_data_r <= mem[req.addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/bce_exec.sv
// execution sequencer: memory clear, operand fetch, execute, write-back, result register
module bce_exec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_v,
  input  bce_pkg::item_t      item,
  input  logic                out_ready,
  input  bce_pkg::word_t      rd_data,
  output bce_pkg::mem_req_t   mem_req,
  output logic                res_v,
  output bce_pkg::res_t       res,
  output bce_pkg::exec_stat_t stat
);
  import bce_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PTR, S_OPR} state_t;

  state_t state_r, state_nxt;
  addr_t  clr_addr_r, clr_addr_nxt;
  word_t  ir_r, ir_nxt;
  addr_t  ea_r, ea_nxt;
  word_t  acc_r, acc_nxt;
  logic   e_r, e_nxt;
  addr_t  pc_r, pc_nxt;
  logic   inf_r, inf_nxt;
  logic   outf_r, outf_nxt;
  logic   ien_r, ien_nxt;
  logic   halt_r, halt_nxt;
  res_t   res_r, res_nxt;
  logic   res_v_r, res_v_nxt;
  logic   take;

  always_comb begin
    logic         slot_free;
    logic         fin;
    logic         unk;
    logic         outv;
    logic [16:0]  sum;
    word_t        inc;
    word_t        w;

    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    ir_nxt       = ir_r;
    ea_nxt       = ea_r;
    acc_nxt      = acc_r;
    e_nxt        = e_r;
    pc_nxt       = pc_r;
    inf_nxt      = inf_r;
    outf_nxt     = outf_r;
    ien_nxt      = ien_r;
    halt_nxt     = halt_r;
    res_nxt      = res_r;
    res_v_nxt    = res_v_r && !out_ready;
    mem_req      = '0;
    take         = 1'b0;
    fin          = 1'b0;
    unk          = 1'b0;
    outv         = 1'b0;
    slot_free    = !res_v_r || out_ready;
    w            = item.instruction;
    sum          = {1'b0, acc_r} + {1'b0, rd_data};
    inc          = rd_data + word_t'(1);

    case (state_r)
      S_CLEAR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_addr_r;
        mem_req.wdata = preload_word(clr_addr_r);
        clr_addr_nxt  = clr_addr_r + addr_t'(1);
        if (clr_addr_r == AddrMax) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_v) begin
          if (!halt_r && w[14:12] != OpExt) begin
            // memory reference: start the pointer or operand read
            take         = 1'b1;
            ir_nxt       = w;
            ea_nxt       = w[11:0];
            mem_req.en   = 1'b1;
            mem_req.addr = w[11:0];
            state_nxt    = w[15] ? S_PTR : S_OPR;
          end else if (slot_free) begin
            take = 1'b1;
            fin  = 1'b1;
            if (!halt_r) begin
              if (!w[15]) begin
                case (w)
                  RegCla: acc_nxt = '0;
                  RegCle: e_nxt = 1'b0;
                  RegCma: acc_nxt = ~acc_r;
                  RegCme: e_nxt = ~e_r;
                  RegCir: begin
                    acc_nxt = {e_r, acc_r[15:1]};
                    e_nxt   = acc_r[0];
                  end
                  RegCil: begin
                    acc_nxt = {acc_r[14:0], e_r};
                    e_nxt   = acc_r[15];
                  end
                  RegInc: acc_nxt = acc_r + word_t'(1);
                  RegSpa: if (!acc_r[15]) pc_nxt = pc_r + addr_t'(1);
                  RegSna: if (acc_r[15]) pc_nxt = pc_r + addr_t'(1);
                  RegSza: if (acc_r == '0) pc_nxt = pc_r + addr_t'(1);
                  RegSze: if (!e_r) pc_nxt = pc_r + addr_t'(1);
                  RegHlt: halt_nxt = 1'b1;
                  default: unk = 1'b1;
                endcase
              end else begin
                case (w)
                  IoInp: begin
                    acc_nxt = item.input_data;
                    inf_nxt = 1'b0;
                  end
                  IoOut: begin
                    outv     = 1'b1;
                    outf_nxt = 1'b0;
                  end
                  IoSki: if (inf_r) pc_nxt = pc_r + addr_t'(1);
                  IoSko: if (outf_r) pc_nxt = pc_r + addr_t'(1);
                  IoIon: ien_nxt = 1'b1;
                  IoIof: ien_nxt = 1'b0;
                  default: unk = 1'b1;
                endcase
              end
            end
          end
        end
      end
      S_PTR: begin
        // indirect: pointer word is back, fetch the operand
        ea_nxt       = rd_data[11:0];
        mem_req.en   = 1'b1;
        mem_req.addr = rd_data[11:0];
        state_nxt    = S_OPR;
      end
      S_OPR: begin
        if (slot_free) begin
          fin          = 1'b1;
          state_nxt    = S_IDLE;
          mem_req.addr = ea_r;
          case (ir_r[14:12])
            OpAnd: acc_nxt = acc_r & rd_data;
            OpAdd: begin
              acc_nxt = sum[15:0];
              e_nxt   = sum[16];
            end
            OpLda: acc_nxt = rd_data;
            OpSta: begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.wdata = acc_r;
            end
            OpBun: pc_nxt = ea_r;
            OpBsa: begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.wdata = {{(WordW-AddrW){1'b0}}, pc_r};
              pc_nxt        = ea_r + addr_t'(1);
            end
            OpIsz: begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.wdata = inc;
              if (inc == '0) pc_nxt = pc_r + addr_t'(1);
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    if (fin) begin
      res_v_nxt = 1'b1;
      res_nxt   = '{acc: acc_nxt, extend_bit: e_nxt, prog_counter: pc_nxt,
                    out_valid: outv, in_flag: inf_nxt, out_flag: outf_nxt,
                    irq_enabled: ien_nxt, halted: halt_nxt, unknown_instr: unk};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      acc_r      <= '0;
      e_r        <= 1'b0;
      pc_r       <= '0;
      inf_r      <= 1'b1;
      outf_r     <= 1'b1;
      ien_r      <= 1'b0;
      halt_r     <= 1'b0;
      res_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      acc_r      <= acc_nxt;
      e_r        <= e_nxt;
      pc_r       <= pc_nxt;
      inf_r      <= inf_nxt;
      outf_r     <= outf_nxt;
      ien_r      <= ien_nxt;
      halt_r     <= halt_nxt;
      res_v_r    <= res_v_nxt;
    end
    ir_r  <= ir_nxt;
    ea_r  <= ea_nxt;
    res_r <= res_nxt;
  end

  assign res_v           = res_v_r;
  assign res             = res_r;
  assign stat.take       = take;
  assign stat.clear_done = (state_r != S_CLEAR);

endmodule

### hw/rtl/basic_computer_instruction_executor_unit.sv
// top level of the accumulator-machine instruction executor
//
// in_if carries one instruction word plus input_data per transaction; out_if returns
// one result transaction per instruction (ac, e, pc, flags, halt and decode status)
// both channels are valid/ready, a transaction moves when valid and ready are high
// an input holding register takes the next instruction while the current one executes,
// and the result register lets work go on while a result waits for out_if.ready
// an accepted item goes through the holding register to the executor, where
//   register, i/o and halted items finish in idle, direct memory-reference items
//   in the operand state and indirect ones in the pointer and then operand state
// register and i/o items: 1 per cycle unless a held result waits for out_if.ready;
// no new item is taken while a memory-reference item uses the single port of the
// 4096-word memory, which serves pointer read, operand read and write-back in turn
// reset (rst_n low, synchronous) clears ac, e, pc, interrupt enable and halt, sets
// both i/o flags, then sweeps the memory writing zero and the preload words at
// addresses 0-6; in_if.ready stays low for the whole sweep
// when out_if.ready is low the result holds, the executor stalls at its next finish
// and the holding register fills, after which in_if.ready drops
module basic_computer_instruction_executor_unit (
  input  logic      clk,
  input  logic      rst_n,
  bce_in_if.sink    in_if,
  bce_out_if.source out_if
);
  import bce_pkg::*;

  // input holding register
  logic               pend_v_r;
  item_t              pend_r;
  logic               in_acc;

  // executor and memory
  mem_req_t           mem_req;
  word_t              rd_data;
  logic               res_v;
  res_t               res;
  exec_stat_t         stat;

  assign in_if.ready = stat.clear_done && (!pend_v_r || stat.take);
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (in_acc) begin
      pend_v_r <= 1'b1;
    end else if (stat.take) begin
      pend_v_r <= 1'b0;
    end
    if (in_acc) begin
      pend_r <= '{instruction: in_if.instruction, input_data: in_if.input_data};
    end
  end

  bce_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bce_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (pend_v_r),
    .item      (pend_r),
    .out_ready (out_if.ready),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res_v     (res_v),
    .res       (res),
    .stat      (stat)
  );

  // result channel straight from the result register
  assign out_if.valid         = res_v;
  assign out_if.acc           = res.acc;
  assign out_if.extend_bit    = res.extend_bit;
  assign out_if.prog_counter  = res.prog_counter;
  assign out_if.out_valid     = res.out_valid;
  assign out_if.in_flag       = res.in_flag;
  assign out_if.out_flag      = res.out_flag;
  assign out_if.irq_enabled   = res.irq_enabled;
  assign out_if.halted        = res.halted;
  assign out_if.unknown_instr = res.unknown_instr;

endmodule

### hw/rtl/bce_checker.sv
// port-level checker for the instruction executor and its bind
module bce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_vld,
  input logic        out_rdy,
  input logic [15:0] acc,
  input logic [11:0] prog_counter,
  input logic        out_valid_f,
  input logic        halted,
  input logic        unknown_instr
);

  // input ready is low right after reset, when the memory sweep starts
  a_no_accept_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(acc) && $stable(prog_counter))
    else $error("stalled result changed");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && halted |-> !out_valid_f && !unknown_instr)
    else $error("halted result reports output or unknown word");

  a_unknown_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && unknown_instr |-> !out_valid_f)
    else $error("unknown word flagged as output");

  // halt is sticky across results
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_rdy && halted |=> !out_vld || halted)
    else $error("halt mark lost");

endmodule

bind basic_computer_instruction_executor_unit bce_checker u_bce_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_vld       (out_if.valid),
  .out_rdy       (out_if.ready),
  .acc           (out_if.acc),
  .prog_counter  (out_if.prog_counter),
  .out_valid_f   (out_if.out_valid),
  .halted        (out_if.halted),
  .unknown_instr (out_if.unknown_instr)
);
